@@ rtl/ccwc_pkg.sv @@
`timescale 1ns / 1ps
// Package for the coin change way counter: table sizing, register reset value,
// action codes and the command/status structs between controller and datapath.
// No dependencies.
package ccwc_pkg;

  localparam int unsigned CCWC_TABLE_DEPTH = 8192;
  localparam int unsigned CCWC_AMOUNT_W    = 13;
  localparam int unsigned CCWC_WAYS_W      = 64;
  localparam logic [CCWC_AMOUNT_W-1:0] CCWC_MAX_AMOUNT_RST = 13'd6000;

  // Action codes carried on the input tuser
  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_ADD   = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_CLEAR,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_QUERY,
    ST_DONE
  } ccwc_state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // latch the input beat
    logic clr_start;  // rewind the sweep index to zero
    logic clr_step;   // write one cleared entry, advance
    logic add_start;  // load the sweep index with the coin value
    logic add_rd;     // issue reads of entry j - coin and entry j
    logic add_wr;     // write the saturated sum into entry j, advance
    logic q_rd;       // issue the read of the queried entry
    logic q_take;     // latch the read data as the result count
    logic load_out;   // move the result into the output register
  } ccwc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] act;
    logic       err;
    logic       idx_at_top;
    logic       idx_at_lim;
    logic       out_free;
  } ccwc_sts_t;

endpackage

@@ rtl/ccwc_ram.sv @@
`timescale 1ns / 1ps
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module ccwc_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and read, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

@@ rtl/ccwc_ctrl.sv @@
`timescale 1ns / 1ps
// Controller of the coin change way counter: sequences clear sweeps, coin
// update sweeps and queries. Depends on ccwc_pkg.
module ccwc_ctrl
  import ccwc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ccwc_sts_t sts_i,
  output ccwc_cmd_t cmd_o
);

  ccwc_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.idx_at_top) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts_i.err) begin
          state_d = ST_DONE;
        end else begin
          unique case (sts_i.act)
            ACT_CLEAR: begin
              cmd_o.clr_start = 1'b1;
              state_d         = ST_CLEAR;
            end
            ACT_ADD: begin
              cmd_o.add_start = 1'b1;
              state_d         = ST_ADD_RD;
            end
            ACT_QUERY: begin
              cmd_o.q_rd = 1'b1;
              state_d    = ST_QUERY;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.idx_at_top) begin
          state_d = ST_DONE;
        end
      end
      ST_ADD_RD: begin
        cmd_o.add_rd = 1'b1;
        state_d      = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        cmd_o.add_wr = 1'b1;
        state_d      = sts_i.idx_at_lim ? ST_DONE : ST_ADD_RD;
      end
      ST_QUERY: begin
        cmd_o.q_take = 1'b1;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/ccwc_dp.sv @@
`timescale 1ns / 1ps
// Datapath of the coin change way counter: limit register, sweep index, way
// table RAM, saturating adder and output register. Depends on ccwc_pkg, ccwc_ram.
module ccwc_dp
  import ccwc_pkg::*;
#(
  parameter int unsigned TableDepth = CCWC_TABLE_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ccwc_cmd_t                cmd_i,
  output ccwc_sts_t                sts_o,
  input  logic [1:0]               in_action_i,
  input  logic [CCWC_AMOUNT_W-1:0] in_value_i,
  input  logic                     cfg_we_i,
  input  logic [CCWC_AMOUNT_W-1:0] cfg_wdata_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic [CCWC_WAYS_W-1:0]   out_ways_o,
  output logic                     out_status_o
);

  localparam int unsigned AddrW = $clog2(TableDepth);
  localparam int unsigned LimW  = (AddrW > CCWC_AMOUNT_W) ? AddrW : CCWC_AMOUNT_W;
  localparam logic [LimW-1:0] TopIdx = LimW'(TableDepth - 1);

  logic [CCWC_AMOUNT_W-1:0] max_amount_q;
  logic [1:0]               act_q;
  logic [LimW-1:0]          value_q;
  logic                     err_q;
  logic [AddrW-1:0]         idx_q, idx_d;
  logic [CCWC_WAYS_W-1:0]   res_ways_q;
  logic                     out_valid_q;
  logic [CCWC_WAYS_W-1:0]   out_ways_q;
  logic                     out_status_q;

  logic [LimW-1:0]          lim;
  logic [LimW-1:0]          in_value_ext;
  logic                     in_err;
  logic                     ram_we;
  logic [AddrW-1:0]         ram_waddr;
  logic [CCWC_WAYS_W-1:0]   ram_wdata;
  logic [AddrW-1:0]         raddr_a, raddr_b;
  logic [CCWC_WAYS_W-1:0]   rdata_a, rdata_b;
  logic [CCWC_WAYS_W:0]     sum;
  logic [CCWC_WAYS_W-1:0]   sat_sum;

  // Effective limit: the register capped at the last table entry
  assign lim = (LimW'(max_amount_q) < TopIdx) ? LimW'(max_amount_q) : TopIdx;

  // Range check of the incoming beat
  assign in_value_ext = LimW'(in_value_i);
  always_comb begin
    case (in_action_i)
      ACT_CLEAR: in_err = 1'b0;
      ACT_ADD:   in_err = (in_value_ext == '0) || (in_value_ext > lim);
      ACT_QUERY: in_err = in_value_ext > lim;
      default:   in_err = 1'b1;
    endcase
  end

  // Limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_amount_q <= CCWC_MAX_AMOUNT_RST;
    end else if (cfg_we_i) begin
      max_amount_q <= cfg_wdata_i;
    end
  end

  // Latch the accepted beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q   <= in_action_i;
      value_q <= in_value_ext;
      err_q   <= in_err;
    end
  end

  // Sweep index
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.clr_start) begin
      idx_d = '0;
    end else if (cmd_i.add_start) begin
      idx_d = value_q[AddrW-1:0];
    end else if (cmd_i.clr_step || cmd_i.add_wr) begin
      idx_d = idx_q + AddrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  // Saturating add of entry j and entry j - coin
  assign sum     = {1'b0, rdata_b} + {1'b0, rdata_a};
  assign sat_sum = sum[CCWC_WAYS_W] ? '1 : sum[CCWC_WAYS_W-1:0];

  // Table port drive
  assign ram_we    = cmd_i.clr_step || cmd_i.add_wr;
  assign ram_waddr = idx_q;
  assign ram_wdata = cmd_i.add_wr ? sat_sum :
                     ((idx_q == '0) ? CCWC_WAYS_W'(1) : '0);
  assign raddr_a   = cmd_i.add_rd ? (idx_q - value_q[AddrW-1:0]) : idx_q;
  assign raddr_b   = cmd_i.q_rd ? value_q[AddrW-1:0] : idx_q;

  ccwc_ram #(
    .Width (CCWC_WAYS_W),
    .Depth (TableDepth)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // Result count: zero unless a query reads the table
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      res_ways_q <= '0;
    end else if (cmd_i.q_take) begin
      res_ways_q <= rdata_b;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_ways_q   <= res_ways_q;
      out_status_q <= err_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_ways_o   = out_ways_q;
  assign out_status_o = out_status_q;

  // Status to the controller
  assign sts_o.act        = act_q;
  assign sts_o.err        = err_q;
  assign sts_o.idx_at_top = LimW'(idx_q) == TopIdx;
  assign sts_o.idx_at_lim = LimW'(idx_q) == lim;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

endmodule

@@ rtl/coin_change_way_counter.sv @@
`timescale 1ns / 1ps
// Coin change way counter. Holds a table of TableDepth 64-bit saturating counts,
// entry j being the number of coin combinations that sum to amount j. After reset
// the block sweeps the table once, accepting no beat, to set entry 0 to one and the
// rest to zero. One beat is worked on at a time: a clear sweeps the whole table; an
// add of coin c steps entry j from c up to the limit, reading entries j - c and j,
// then writing their saturated sum into entry j (through the two-read single-write
// table RAM); a query reads one entry; an error goes straight to the result.
// The limit is min(max_amount, TableDepth - 1). The result waits in an output
// register, so the next beat is taken while it is still unclaimed.
// Depends on ccwc_pkg, ccwc_ctrl, ccwc_dp, ccwc_ram.
module coin_change_way_counter
  import ccwc_pkg::*;
#(
  parameter int unsigned TableDepth = CCWC_TABLE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [12:0] value, [15:13] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] ways
  output logic        m_axis_tuser,   // [0] status
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i     // [12:0] max_amount
);

  ccwc_cmd_t cmd;
  ccwc_sts_t sts;

  ccwc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ccwc_dp #(
    .TableDepth (TableDepth)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_action_i  (s_axis_tuser),
    .in_value_i   (s_axis_tdata[CCWC_AMOUNT_W-1:0]),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_ways_o   (m_axis_tdata),
    .out_status_o (m_axis_tuser)
  );

  // One beat at a time: input closes right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted on two consecutive cycles");

  // An error result never carries a count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("error result with nonzero ways");

  // A result is never presented in the cycle right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
    else $error("result appeared before decode");

endmodule
